// File: rtl/dstq_pkg.sv
// Shared types, constants and helpers for the deadline-sorted timer queue.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package dstq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int ID_W       = 4;
  localparam int NUM_IDS    = 2 ** ID_W;
  localparam int EXP_W      = 32;
  localparam int CNT_W      = 26;

  typedef enum logic [1:0] {
    CMD_START_ABS = 2'd0,
    CMD_START_REL = 2'd1,
    CMD_STOP      = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RK_DONE    = 2'd0,
    RK_REJECT  = 2'd1,
    RK_EXPIRED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY,
    ST_TICK
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    logic             is_stop;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] key;
  } cell_ctl_t;

  function automatic logic runs_before(input logic [EXP_W-1:0] a, input logic [EXP_W-1:0] b);
    logic [EXP_W-1:0] diff;
    diff = a - b;
    return diff[EXP_W-1];
  endfunction

endpackage

`default_nettype wire

// File: rtl/dstq_in_if.sv
// Command channel of the timer queue: valid/ready plus one command item.
// Depends on dstq_pkg for field widths.
`default_nettype none

interface dstq_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [dstq_pkg::ID_W-1:0]   timer_id;
  logic [dstq_pkg::EXP_W-1:0]  time_value;
  logic [dstq_pkg::CNT_W-1:0]  count_now;

  modport source (output valid, output command, output timer_id, output time_value,
                  output count_now, input ready);
  modport sink   (input valid, input command, input timer_id, input time_value,
                  input count_now, output ready);
endinterface

`default_nettype wire

// File: rtl/dstq_out_if.sv
// Result channel of the timer queue: valid/ready plus one result item.
// Depends on dstq_pkg for field widths.
`default_nettype none

interface dstq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  result_kind;
  logic [dstq_pkg::ID_W-1:0]   expired_id;
  logic [dstq_pkg::CNT_W-1:0]  compare_value;
  logic                        compare_armed;
  logic                        last_of_run;

  modport source (output valid, output result_kind, output expired_id,
                  output compare_value, output compare_armed, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input expired_id,
                  input compare_value, input compare_armed, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/dstq_cell.sv
// One slot of the sorted timer chain: holds an entry, compares it against a key,
// and shifts toward either neighbor on insert or remove. Depends on dstq_pkg.
`default_nettype none

module dstq_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  dstq_pkg::cell_ctl_t  ctl,
  input  dstq_pkg::entry_t     prev_ent,
  input  dstq_pkg::entry_t     next_ent,
  input  wire                  found_in,
  output logic                 found_out,
  output logic                 hit,
  output dstq_pkg::entry_t     ent
);

  logic                           valid_r, valid_nxt;
  logic                           flag_r, flag_nxt;
  logic [dstq_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [dstq_pkg::EXP_W-1:0]     exp_r, exp_nxt;

  always_comb begin
    flag_nxt  = flag_r;
    valid_nxt = valid_r;
    id_nxt    = id_r;
    exp_nxt   = exp_r;
    case (ctl.op)
      dstq_pkg::CELL_CMP: begin
        if (ctl.is_stop) begin
          flag_nxt = valid_r && (id_r == ctl.id);
        end else begin
          flag_nxt = !valid_r || dstq_pkg::runs_before(ctl.key, exp_r);
        end
      end
      dstq_pkg::CELL_INSERT: begin
        if (found_in) begin
          valid_nxt = prev_ent.valid;
          id_nxt    = prev_ent.id;
          exp_nxt   = prev_ent.expiry;
        end else if (flag_r) begin
          valid_nxt = 1'b1;
          id_nxt    = ctl.id;
          exp_nxt   = ctl.key;
        end
      end
      dstq_pkg::CELL_REMOVE: begin
        if (found_in || flag_r) begin
          valid_nxt = next_ent.valid;
          id_nxt    = next_ent.id;
          exp_nxt   = next_ent.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    exp_r <= exp_nxt;
  end

  assign found_out  = found_in | flag_r;
  assign hit        = flag_r;
  assign ent.valid  = valid_r;
  assign ent.id     = id_r;
  assign ent.expiry = exp_r;

endmodule

`default_nettype wire

// File: rtl/deadline_sorted_timer_queue_unit.sv
// Deadline-sorted one-shot timer queue: command sequencer, compare register and
// a chain of dstq_cell slots. Depends on dstq_pkg, dstq_in_if, dstq_out_if, dstq_cell.
//
// Usage:
//   in_ch  carries commands (start absolute, start relative, stop, tick); a transfer
//          happens when valid and ready are both high. out_ch carries results.
//   Start and stop run one compare pass across the chain of slots (ST_CMP),
//   then one shift pass (ST_APPLY) that also writes the result.
//   A tick writes one result per expired timer plus one status result; each
//   expired head leaves the chain in one shift pass, so a tick that empties a
//   full queue writes MAX_TIMERS + 1 results after its transfer.
//   One command is worked at a time; the next command can transfer as soon as
//   the sequencer is back in ST_IDLE, which it enters when the last result of
//   the previous one is written, even while that result still waits in the output register.
//   When out_ch.ready is low the pending result holds and the sequencer stalls
//   before producing the next one; nothing is dropped.
//   Reset (rst_n low, synchronous) empties the queue, clears the compare
//   register and its enable, and drops any pending result.
`default_nettype none

module deadline_sorted_timer_queue_unit (
  input  wire           clk,
  input  wire           rst_n,
  dstq_in_if.sink       in_ch,
  dstq_out_if.source    out_ch
);

  localparam int N = dstq_pkg::MAX_TIMERS;

  dstq_pkg::state_t                 state_r, state_nxt;
  dstq_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [dstq_pkg::ID_W-1:0]        id_r, id_nxt;
  logic [dstq_pkg::EXP_W-1:0]       key_r, key_nxt;
  logic [dstq_pkg::EXP_W-1:0]       now_r, now_nxt;
  logic [dstq_pkg::NUM_IDS-1:0]     queued_r, queued_nxt;
  logic [dstq_pkg::CNT_W-1:0]       compare_r, compare_nxt;
  logic                             enable_r, enable_nxt;

  logic                             out_valid_r, out_valid_nxt;
  dstq_pkg::kind_t                  out_kind_r, out_kind_nxt;
  logic [dstq_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic [dstq_pkg::CNT_W-1:0]       out_cmp_r, out_cmp_nxt;
  logic                             out_arm_r, out_arm_nxt;
  logic                             out_last_r, out_last_nxt;

  dstq_pkg::cell_ctl_t              ctl;
  dstq_pkg::entry_t                 ents [N];
  logic [N:0]                       found;
  logic [N-1:0]                     hits;
  logic [N-1:0]                     cell_valid;
  logic                             pop;
  logic                             out_free;
  logic                             in_xfer;
  logic                             id_ok;
  logic                             head_expired;
  logic [dstq_pkg::EXP_W-1:0]       now_ext;

  assign found[0] = pop;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dstq_pkg::entry_t prev_e, next_e;
    if (g == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid
      assign prev_e = ents[g-1];
    end
    if (g == N - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ents[g+1];
    end
    dstq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_ent  (prev_e),
      .next_ent  (next_e),
      .found_in  (found[g]),
      .found_out (found[g+1]),
      .hit       (hits[g]),
      .ent       (ents[g])
    );
    assign cell_valid[g] = ents[g].valid;
  end

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign id_ok        = int'(id_r) < N;
  assign head_expired = ents[0].valid && !dstq_pkg::runs_before(now_r, ents[0].expiry);
  assign now_ext      = {{(dstq_pkg::EXP_W-dstq_pkg::CNT_W){1'b0}}, in_ch.count_now};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    queued_nxt    = queued_r;
    compare_nxt   = compare_r;
    enable_nxt    = enable_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_cmp_nxt   = out_cmp_r;
    out_arm_nxt   = out_arm_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    ctl.op        = dstq_pkg::CELL_HOLD;
    ctl.is_stop   = (cmd_r == dstq_pkg::CMD_STOP);
    ctl.id        = id_r;
    ctl.key       = key_r;

    case (state_r)
      dstq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = dstq_pkg::cmd_t'(in_ch.command);
          id_nxt  = in_ch.timer_id;
          now_nxt = now_ext;
          key_nxt = (dstq_pkg::cmd_t'(in_ch.command) == dstq_pkg::CMD_START_REL)
                    ? now_ext + in_ch.time_value : in_ch.time_value;
          state_nxt = (dstq_pkg::cmd_t'(in_ch.command) == dstq_pkg::CMD_TICK)
                      ? dstq_pkg::ST_TICK : dstq_pkg::ST_CMP;
        end
      end
      dstq_pkg::ST_CMP: begin
        ctl.op    = dstq_pkg::CELL_CMP;
        state_nxt = dstq_pkg::ST_APPLY;
      end
      dstq_pkg::ST_APPLY: begin
        if (out_free) begin
          out_kind_nxt = dstq_pkg::RK_DONE;
          if (cmd_r == dstq_pkg::CMD_STOP) begin
            if (id_ok && queued_r[id_r]) begin
              ctl.op           = dstq_pkg::CELL_REMOVE;
              queued_nxt[id_r] = 1'b0;
              if (hits[0]) begin
                if (ents[1].valid) begin
                  compare_nxt = ents[1].expiry[dstq_pkg::CNT_W-1:0];
                  enable_nxt  = 1'b1;
                end else begin
                  enable_nxt  = 1'b0;
                end
              end
            end
          end else if (!id_ok || queued_r[id_r] || ents[N-1].valid) begin
            out_kind_nxt = dstq_pkg::RK_REJECT;
          end else begin
            ctl.op           = dstq_pkg::CELL_INSERT;
            queued_nxt[id_r] = 1'b1;
            if (hits[0]) begin
              compare_nxt = key_r[dstq_pkg::CNT_W-1:0];
              enable_nxt  = 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_cmp_nxt   = compare_nxt;
          out_arm_nxt   = enable_nxt;
          out_last_nxt  = 1'b1;
          state_nxt     = dstq_pkg::ST_IDLE;
        end
      end
      dstq_pkg::ST_TICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (head_expired) begin
            ctl.op                  = dstq_pkg::CELL_REMOVE;
            pop                     = 1'b1;
            queued_nxt[ents[0].id]  = 1'b0;
            out_kind_nxt            = dstq_pkg::RK_EXPIRED;
            out_id_nxt              = ents[0].id;
            out_cmp_nxt             = compare_r;
            out_arm_nxt             = enable_r;
            out_last_nxt            = 1'b0;
          end else begin
            if (ents[0].valid) begin
              compare_nxt = ents[0].expiry[dstq_pkg::CNT_W-1:0];
            end
            enable_nxt   = ents[0].valid;
            out_kind_nxt = dstq_pkg::RK_DONE;
            out_id_nxt   = '0;
            out_cmp_nxt  = compare_nxt;
            out_arm_nxt  = enable_nxt;
            out_last_nxt = 1'b1;
            state_nxt    = dstq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dstq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dstq_pkg::ST_IDLE;
      queued_r    <= '0;
      compare_r   <= '0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      queued_r    <= queued_nxt;
      compare_r   <= compare_nxt;
      enable_r    <= enable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_cmp_r  <= out_cmp_nxt;
    out_arm_r  <= out_arm_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready          = (state_r == dstq_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_kind_r;
  assign out_ch.expired_id    = out_id_r;
  assign out_ch.compare_value = out_cmp_r;
  assign out_ch.compare_armed = out_arm_r;
  assign out_ch.last_of_run   = out_last_r;

  a_chain_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, cell_valid} + {{N{1'b0}}, 1'b1}))
    else $error("queue slots not packed toward the head");

  a_queued_matches_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == $countones(cell_valid))
    else $error("queued flags disagree with occupied slots");

  a_enable_follows_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dstq_pkg::ST_IDLE) |-> (enable_r == ents[0].valid))
    else $error("compare enable does not follow queue head");

  a_pop_keeps_compare: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> $stable(compare_r) && $stable(enable_r))
    else $error("compare changed while popping expired heads");

endmodule

`default_nettype wire
